FILE: rtl/label_box_placement_core_defines.svh
// Assertion macros shared by the block's checkers.
`ifndef LABEL_BOX_PLACEMENT_CORE_DEFINES_SVH
`define LABEL_BOX_PLACEMENT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LBP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lbp_pkg.sv
`timescale 1ns / 1ps

package lbp_pkg;

  // Internal coordinate width: covers anchor +/- box size and all biases
  localparam int XW = 19;

  localparam int AXW      = 16;  // anchor coordinate width
  localparam int BOXW     = 10;  // box size width
  localparam int WINW     = 13;  // window size register width
  localparam int POSW     = 17;  // result position width
  localparam int OFSW     = 13;  // result offset width
  localparam int CHOICE_W = 4;

  localparam int NUM_TRIALS = 8;
  localparam int TRIAL_IW   = 3;

  localparam logic signed [XW-1:0] CENTRE_BIAS = XW'(16);
  localparam logic signed [XW-1:0] LIFT_GAP    = XW'(60);
  localparam logic signed [XW-1:0] DIAG_STEP   = XW'(64);

  localparam logic [CHOICE_W-1:0] CHOICE_FALLBACK = CHOICE_W'(8);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WINW-1:0] WINDOW_WIDTH_RESET  = WINW'(640);
  localparam logic [WINW-1:0] WINDOW_HEIGHT_RESET = WINW'(480);

  // One request held in the input stage
  typedef struct packed {
    logic signed [AXW-1:0] anchor_x;
    logic signed [AXW-1:0] anchor_y;
    logic [BOXW-1:0]       box_width;
    logic [BOXW-1:0]       box_height;
    logic                  no_lift;
  } lbp_req_t;

endpackage

FILE: rtl/label_box_placement_core.sv
`timescale 1ns / 1ps

// Label box placement core. Takes one request (anchor point in screen
// coordinates, box size, no-lift flag) per cycle while not stalled and
// returns one placement per request, in order. Each request passes through
// the input register and then the result register. All eight candidate
// positions are tested in parallel against the window size in the logic
// between those two registers, and the lowest-numbered fitting candidate
// wins; when none fits, the centered and lifted fallback is reported with
// its own choice code. Throughput is one request per cycle while the result
// side does not stall. The window size registers are written through the
// cfg port, which is always ready; write them only while no request is in
// flight.
module label_box_placement_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lbp_pkg::AXW-1:0]        in_anchor_x,
  input  logic signed [lbp_pkg::AXW-1:0]        in_anchor_y,
  input  logic [lbp_pkg::BOXW-1:0]              in_box_width,
  input  logic [lbp_pkg::BOXW-1:0]              in_box_height,
  input  logic                                  in_no_lift,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [lbp_pkg::POSW-1:0]       out_box_x,
  output logic signed [lbp_pkg::POSW-1:0]       out_box_y,
  output logic signed [lbp_pkg::OFSW-1:0]       out_offset_x,
  output logic signed [lbp_pkg::OFSW-1:0]       out_offset_y,
  output logic [lbp_pkg::CHOICE_W-1:0]          out_choice,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lbp_pkg::WINW-1:0]              cfg_data
);
  import lbp_pkg::*;

  logic [WINW-1:0] win_w_r, win_h_r;

  lbp_req_t req_r;
  logic     req_valid_r;

  logic                       res_valid_r;
  logic signed [POSW-1:0]     box_x_r, box_y_r;
  logic signed [OFSW-1:0]     offset_x_r, offset_y_r;
  logic [CHOICE_W-1:0]        choice_r;

  logic res_adv, req_adv;

  logic signed [POSW-1:0] box_x_nxt, box_y_nxt;
  logic signed [OFSW-1:0] offset_x_nxt, offset_y_nxt;
  logic [CHOICE_W-1:0]    choice_nxt;

  // Flow control: result register refills when empty or taken
  assign res_adv  = !res_valid_r || !out_stall;
  assign req_adv  = !req_valid_r || res_adv;
  assign in_stall = !req_adv;

  assign cfg_ready = 1'b1;

  // Window size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r <= WINDOW_WIDTH_RESET;
      win_h_r <= WINDOW_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_WIDTH:  win_w_r <= cfg_data;
        REG_WINDOW_HEIGHT: win_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (req_adv) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_adv && in_valid) begin
      req_r.anchor_x   <= in_anchor_x;
      req_r.anchor_y   <= in_anchor_y;
      req_r.box_width  <= in_box_width;
      req_r.box_height <= in_box_height;
      req_r.no_lift    <= in_no_lift;
    end
  end

  // Candidate positions, fit tests and priority pick
  always_comb begin
    logic signed [XW-1:0] ax, ay, w, h, half, cx, lifted, row0, diag_y;
    logic signed [XW-1:0] win_w, win_h;
    logic signed [XW-1:0] tx [NUM_TRIALS];
    logic signed [XW-1:0] ty [NUM_TRIALS];
    logic [NUM_TRIALS-1:0] fit;
    logic [CHOICE_W-1:0]   pick;
    logic signed [XW-1:0]  x, y;

    ax     = {{(XW-AXW){req_r.anchor_x[AXW-1]}}, req_r.anchor_x};
    ay     = {{(XW-AXW){req_r.anchor_y[AXW-1]}}, req_r.anchor_y};
    w      = {{(XW-BOXW){1'b0}}, req_r.box_width};
    h      = {{(XW-BOXW){1'b0}}, req_r.box_height};
    half   = {{(XW-BOXW+1){1'b0}}, req_r.box_width[BOXW-1:1]};
    win_w  = {{(XW-WINW){1'b0}}, win_w_r};
    win_h  = {{(XW-WINW){1'b0}}, win_h_r};
    cx     = ax + CENTRE_BIAS - half;
    lifted = ay - h - LIFT_GAP;
    row0   = req_r.no_lift ? ay : lifted;
    diag_y = ay - CENTRE_BIAS - h;

    tx[0] = cx;                          ty[0] = row0;
    tx[1] = cx - half;                   ty[1] = row0;
    tx[2] = cx - half + w;               ty[2] = row0;
    tx[3] = ax - CENTRE_BIAS - w;        ty[3] = diag_y;
    tx[4] = ax + DIAG_STEP - CENTRE_BIAS; ty[4] = diag_y;
    tx[5] = cx;                          ty[5] = ay;
    tx[6] = cx - half;                   ty[6] = ay;
    tx[7] = cx - half + w;               ty[7] = ay;

    // Box wholly inside the window
    for (int k = 0; k < NUM_TRIALS; k++) begin
      fit[k] = !tx[k][XW-1] && (tx[k] + w - XW'(1) < win_w) &&
               !ty[k][XW-1] && (ty[k] + h - XW'(1) < win_h);
    end

    // Lowest fitting index wins
    pick = CHOICE_FALLBACK;
    for (int k = NUM_TRIALS - 1; k >= 0; k--) begin
      if (fit[k]) pick = CHOICE_W'(k);
    end

    if (pick == CHOICE_FALLBACK) begin
      x = cx;
      y = lifted;
    end else begin
      x = tx[pick[TRIAL_IW-1:0]];
      y = ty[pick[TRIAL_IW-1:0]];
    end

    box_x_nxt    = x[POSW-1:0];
    box_y_nxt    = y[POSW-1:0];
    offset_x_nxt = OFSW'(x - ax);
    offset_y_nxt = OFSW'(y - ay);
    choice_nxt   = pick;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_adv) begin
      res_valid_r <= req_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_adv && req_valid_r) begin
      box_x_r    <= box_x_nxt;
      box_y_r    <= box_y_nxt;
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
      choice_r   <= choice_nxt;
    end
  end

  assign out_valid    = res_valid_r;
  assign out_box_x    = box_x_r;
  assign out_box_y    = box_y_r;
  assign out_offset_x = offset_x_r;
  assign out_offset_y = offset_y_r;
  assign out_choice   = choice_r;

endmodule

FILE: rtl/lbp_checker.sv
`timescale 1ns / 1ps
`include "label_box_placement_core_defines.svh"

module lbp_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [lbp_pkg::POSW-1:0]       out_box_x,
  input logic signed [lbp_pkg::POSW-1:0]       out_box_y,
  input logic signed [lbp_pkg::OFSW-1:0]       out_offset_y,
  input logic [lbp_pkg::CHOICE_W-1:0]          out_choice,
  input logic                                  cfg_valid,
  input logic                                  cfg_ready
);
  import lbp_pkg::*;

  // A stalled result stays offered
  `LBP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
                   "result dropped while stalled")

  // Request side only backs up when the result side does
  `LBP_ASSERT_NOW(a_stall_cause, clk, rst_n, !out_stall, !in_stall,
                  "request stalled without result stall")

  // A fitting candidate never lies left of or above the window
  `LBP_ASSERT_NOW(a_fit_inside, clk, rst_n, out_valid && out_choice != CHOICE_FALLBACK,
                  !out_box_x[POSW-1] && !out_box_y[POSW-1], "fitted box outside window")

  // Fallback is always lifted above the anchor
  `LBP_ASSERT_NOW(a_fallback_lift, clk, rst_n, out_valid && out_choice == CHOICE_FALLBACK,
                  out_offset_y[OFSW-1], "fallback not lifted")

  // Configuration writes are never held off
  `LBP_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "config write held off")

endmodule

bind label_box_placement_core lbp_checker u_lbp_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lbp_pkg::*;

  localparam int PIPE_LATENCY = 2;     // input register plus result register
  localparam int HOLD_CYCLES  = 60;    // long receiver hold-off, fills the pipe
  localparam int CHUNK        = 50;    // requests per idling mode
  localparam int IDLE_GUARD   = 20000; // cycles allowed for draining

  // register indexes past the end of the register list, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic signed [POSW-1:0] box_x;
    logic signed [POSW-1:0] box_y;
    logic signed [OFSW-1:0] offset_x;
    logic signed [OFSW-1:0] offset_y;
    logic [CHOICE_W-1:0]    choice;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic signed [AXW-1:0]  in_anchor_x = '0;
  logic signed [AXW-1:0]  in_anchor_y = '0;
  logic [BOXW-1:0]        in_box_width = '0;
  logic [BOXW-1:0]        in_box_height = '0;
  logic                   in_no_lift = 1'b0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [POSW-1:0] out_box_x;
  logic signed [POSW-1:0] out_box_y;
  logic signed [OFSW-1:0] out_offset_x;
  logic signed [OFSW-1:0] out_offset_y;
  logic [CHOICE_W-1:0]    out_choice;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [WINW-1:0]        cfg_data = '0;

  label_box_placement_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_anchor_x  (in_anchor_x),
    .in_anchor_y  (in_anchor_y),
    .in_box_width (in_box_width),
    .in_box_height(in_box_height),
    .in_no_lift   (in_no_lift),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_box_x    (out_box_x),
    .out_box_y    (out_box_y),
    .out_offset_x (out_offset_x),
    .out_offset_y (out_offset_y),
    .out_choice   (out_choice),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Window size as the block should currently hold it
  logic [WINW-1:0] view_w = WINDOW_WIDTH_RESET;
  logic [WINW-1:0] view_h = WINDOW_HEIGHT_RESET;

  lbp_req_t   requests_queued[$];
  placement_t placements_due[$];

  bit in_xfer  = 1'b0;
  bit out_xfer = 1'b0;

  int send_max_gap   = 0;
  int recv_max_stall = 0;
  int hold_reqs      = 0;

  int requests_issued  = 0;
  int results_seen     = 0;
  int mismatches       = 0;
  int settings_used    = 1;
  int choice_tally[0:8];

  // Expected placement for one request under the current window size
  function automatic placement_t place_label(lbp_req_t r);
    int ax, ay, w, h, half, cx, lifted, x, y, ww, wh;
    int tx[8];
    int ty[8];
    placement_t p;
    ax = $signed(r.anchor_x);
    ay = $signed(r.anchor_y);
    w = r.box_width;
    h = r.box_height;
    ww = view_w;
    wh = view_h;
    half = w / 2;
    cx = ax + 16 - half;
    lifted = ay - (h + 60);
    tx[0] = cx;             ty[0] = r.no_lift ? ay : lifted;
    tx[1] = cx - half;      ty[1] = ty[0];
    tx[2] = cx - half + w;  ty[2] = ty[0];
    tx[3] = ax - 16 - w;    ty[3] = ay - 16 - h;
    tx[4] = tx[3] + w + 64; ty[4] = ty[3];
    tx[5] = cx;             ty[5] = ay;
    tx[6] = cx - half;      ty[6] = ay;
    tx[7] = cx - half + w;  ty[7] = ay;
    // scan from the back so the lowest fitting candidate is kept
    x = cx;
    y = lifted;
    p.choice = CHOICE_FALLBACK;
    for (int k = NUM_TRIALS - 1; k >= 0; k--) begin
      if (tx[k] >= 0 && tx[k] + w - 1 < ww && ty[k] >= 0 && ty[k] + h - 1 < wh) begin
        x = tx[k];
        y = ty[k];
        p.choice = CHOICE_W'(k);
      end
    end
    p.box_x = POSW'(x);
    p.box_y = POSW'(y);
    p.offset_x = OFSW'(x - ax);
    p.offset_y = OFSW'(y - ay);
    return p;
  endfunction

  // Mostly anchors around the window with modest boxes; some fully random
  function automatic lbp_req_t random_request();
    lbp_req_t r;
    int sel;
    sel = $urandom_range(0, 9);
    r.no_lift = 1'($urandom_range(0, 1));
    if (sel < 2) begin
      r.anchor_x = AXW'($urandom);
      r.anchor_y = AXW'($urandom);
      r.box_width = BOXW'($urandom);
      r.box_height = BOXW'($urandom);
    end else begin
      r.anchor_x = AXW'(int'($urandom_range(0, view_w + 400)) - 200);
      r.anchor_y = AXW'(int'($urandom_range(0, view_h + 400)) - 200);
      if (sel < 4) begin
        r.box_width = BOXW'($urandom_range(0, 3));
        r.box_height = BOXW'($urandom_range(0, 3));
      end else begin
        r.box_width = BOXW'($urandom_range(0, 300));
        r.box_height = BOXW'($urandom_range(0, 200));
      end
    end
    return r;
  endfunction

  task automatic queue_request(input int ax, input int ay, input int w, input int h,
                               input bit nl);
    lbp_req_t r;
    r.anchor_x = AXW'(ax);
    r.anchor_y = AXW'(ay);
    r.box_width = BOXW'(w);
    r.box_height = BOXW'(h);
    r.no_lift = nl;
    requests_queued.push_back(r);
    requests_issued++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      requests_queued.push_back(random_request());
      requests_issued++;
    end
  endtask

  // Wait until every issued request has produced its placement
  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    while (results_seen < requests_issued && guard < IDLE_GUARD) begin
      @(negedge clk);
      guard++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Register write; the block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WINW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WINDOW_WIDTH) view_w = data;
    else if (idx == REG_WINDOW_HEIGHT) view_h = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random requests in chunks, each chunk with its own idling mode
  task automatic run_random(input int count);
    int n;
    while (count > 0) begin
      n = (count < CHUNK) ? count : CHUNK;
      case ($urandom_range(0, 3))
        0: begin
          send_max_gap = 0;
          recv_max_stall = 0;
        end
        1: begin
          send_max_gap = 8;
          recv_max_stall = 8;
        end
        2: begin
          send_max_gap = 0;
          recv_max_stall = 8;
        end
        default: begin
          send_max_gap = 8;
          recv_max_stall = 0;
        end
      endcase
      queue_random(n);
      count -= n;
      while (requests_queued.size() != 0) @(posedge clk);
    end
  endtask

  task automatic new_window(input int w, input int h, input int count);
    wait_idle();
    write_reg(REG_WINDOW_WIDTH, WINW'(w));
    write_reg(REG_WINDOW_HEIGHT, WINW'(h));
    settings_used++;
    run_random(count);
  endtask

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Request driver: one transfer per queued request, random gap after each
  int gap_left = 0;
  always @(negedge clk) begin : request_driver
    lbp_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (requests_queued.size() != 0) begin
        r = requests_queued.pop_front();
        in_anchor_x <= r.anchor_x;
        in_anchor_y <= r.anchor_y;
        in_box_width <= r.box_width;
        in_box_height <= r.box_height;
        in_no_lift <= r.no_lift;
        in_valid <= 1'b1;
        gap_left = $urandom_range(0, send_max_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall per result, plus long hold-offs on request
  int stall_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  always @(negedge clk) begin : result_receiver
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (out_xfer) stall_left = $urandom_range(0, recv_max_stall);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      if (out_valid) stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each request transfer, check on each result transfer
  always @(posedge clk) begin : monitor
    lbp_req_t r;
    placement_t want;
    in_xfer = rst_n && in_valid && !in_stall;
    out_xfer = rst_n && out_valid && !out_stall;
    if (in_xfer) begin
      r.anchor_x = in_anchor_x;
      r.anchor_y = in_anchor_y;
      r.box_width = in_box_width;
      r.box_height = in_box_height;
      r.no_lift = in_no_lift;
      placements_due.push_back(place_label(r));
    end
    if (out_xfer) begin
      results_seen++;
      if (out_choice <= CHOICE_FALLBACK) choice_tally[out_choice]++;
      if (placements_due.size() == 0) begin
        $error("placement transfer with no request outstanding");
        mismatches++;
      end else begin
        want = placements_due.pop_front();
        if (out_box_x !== want.box_x) begin
          $error("box_x: expected %0d, got %0d", want.box_x, out_box_x);
          mismatches++;
        end
        if (out_box_y !== want.box_y) begin
          $error("box_y: expected %0d, got %0d", want.box_y, out_box_y);
          mismatches++;
        end
        if (out_offset_x !== want.offset_x) begin
          $error("offset_x: expected %0d, got %0d", want.offset_x, out_offset_x);
          mismatches++;
        end
        if (out_offset_y !== want.offset_y) begin
          $error("offset_y: expected %0d, got %0d", want.offset_y, out_offset_y);
          mismatches++;
        end
        if (out_choice !== want.choice) begin
          $error("choice: expected %0d, got %0d", want.choice, out_choice);
          mismatches++;
        end
      end
    end
  end

  // Hang guard
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    for (int i = 0; i < 9; i++) choice_tally[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed cases in the reset window (640 x 480), w=100 h=20 walks all choices
    send_max_gap = 2;
    recv_max_stall = 2;
    queue_request(300, 200, 100, 20, 0);     // centered, lifted
    queue_request(300, 200, 100, 20, 1);     // centered, at anchor row
    queue_request(600, 200, 100, 20, 0);     // shifted left
    queue_request(30, 200, 100, 20, 0);      // shifted right
    queue_request(300, 70, 100, 20, 0);      // up-left
    queue_request(100, 70, 100, 20, 0);      // up-right
    queue_request(300, 20, 100, 20, 0);      // anchor row centered
    queue_request(600, 20, 100, 20, 0);      // anchor row left
    queue_request(30, 20, 100, 20, 0);       // anchor row right
    queue_request(300, -100, 100, 20, 0);    // nothing fits, fallback
    queue_request(-32768, -32768, 0, 0, 0);
    queue_request(32767, 32767, 1023, 1023, 1);
    queue_request(-32768, 32767, 1023, 0, 1);
    queue_request(32767, -32768, 0, 1023, 0);
    queue_request(-16, 0, 0, 0, 1);          // empty box at the origin
    queue_request(-17, 0, 1, 1, 1);
    queue_request(608, 0, 32, 480, 1);       // touches right and bottom edges
    queue_request(609, 0, 32, 480, 1);       // one pixel over
    queue_request(300, 200, 101, 20, 0);     // odd width, halving truncates
    queue_request(0, 0, 1023, 1023, 0);
    queue_request(320, 240, 640, 480, 1);
    queue_request(304, 0, 640, 480, 1);      // box equals the window
    queue_request(-1, -1, 1023, 1, 0);
    while (requests_queued.size() != 0) @(posedge clk);
    wait_idle();

    // back-pressure: long receiver hold while requests keep coming
    send_max_gap = 0;
    recv_max_stall = 0;
    hold_reqs++;
    queue_random(40);
    while (requests_queued.size() != 0) @(posedge clk);
    wait_idle();

    run_random(460);
    new_window(1920, 1080, 300);
    new_window(1, 1, 150);
    new_window(0, 0, 100);
    new_window(8191, 8191, 250);
    new_window(4096, 1, 150);
    new_window(200, 4096, 200);
    wait_idle();
    write_reg(REG_SPARE_A, WINW'(8191));
    write_reg(REG_SPARE_B, WINW'(4095));
    new_window(100, 60, 300);

    wait_idle();
    repeat (PIPE_LATENCY * 4) @(posedge clk);
    if (results_seen != requests_issued || placements_due.size() != 0) begin
      $error("%0d requests issued but %0d placements returned",
             requests_issued, results_seen);
      mismatches++;
    end

    $display("Checked %0d placements over %0d window sizes, %0d mismatches.",
             results_seen, settings_used, mismatches);
    $display("Choices taken 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             choice_tally[0], choice_tally[1], choice_tally[2], choice_tally[3],
             choice_tally[4], choice_tally[5], choice_tally[6], choice_tally[7],
             choice_tally[8]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lbp_pkg.sv
rtl/label_box_placement_core.sv
rtl/lbp_checker.sv
test/tb_top.sv
